// ===== sv/sclc_pkg.sv =====
// Shared types for the software cursor lock controller.
`timescale 1ns / 1ps

package sclc_pkg;

    // Event codes of the input item
    typedef enum logic [2:0] {
        MODE_SHAPE  = 3'd0,
        MODE_SERVER = 3'd1,
        MODE_MOVE   = 3'd2,
        MODE_LOCK   = 3'd3,
        MODE_UNLOCK = 3'd4
    } mode_t;

    // Screen action codes of a result item
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RESTORE = 2'd1,
        ACT_DRAW    = 2'd2
    } action_t;

    localparam logic [15:0] FB_WIDTH_RESET  = 16'd640;
    localparam logic [15:0] FB_HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] area_x;
        logic [15:0] area_y;
        logic [15:0] area_w;
        logic [15:0] area_h;
        logic        now_present;
        logic        now_hidden;
        logic        last;
    } res_item_t;

    typedef struct packed {
        logic [15:0] fb_width;
        logic [15:0] fb_height;
        logic        ignore_shape;
    } cfg_t;

    typedef struct packed {
        logic        present;
        logic        hidden;
        logic        locked;
        logic [15:0] cur_x;
        logic [15:0] cur_y;
        logic [15:0] shape_w;
        logic [15:0] shape_h;
        logic [15:0] hot_x;
        logic [15:0] hot_y;
        logic [15:0] lock_left;
        logic [15:0] lock_top;
        logic [16:0] lock_w;
        logic [16:0] lock_h;
    } state_t;

    // Result of processing one item: new state and up to two result items
    typedef struct packed {
        state_t    nxt;
        res_item_t res0;
        res_item_t res1;
        logic      two;
    } ev_t;

endpackage

// ===== sv/sclc_event.sv =====
// Event decode, state update and clipped cursor areas for one item.
`timescale 1ns / 1ps

module sclc_event (
    input  sclc_pkg::state_t   st_i,
    input  sclc_pkg::in_item_t item_i,
    input  sclc_pkg::cfg_t     cfg_i,
    output sclc_pkg::ev_t      ev_o
);

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] len;
    } axis_t;

    // Clip one axis of the cursor rectangle to the framebuffer
    function automatic axis_t clip_axis(input logic [15:0] cur, input logic [15:0] hot,
                                        input logic [15:0] size, input logic [15:0] lim);
        logic signed [18:0] pos;
        logic signed [18:0] len;
        logic signed [18:0] lm;
        axis_t              a;
        pos = $signed({3'b000, cur}) - $signed({3'b000, hot});
        len = $signed({3'b000, size});
        lm  = $signed({3'b000, lim});
        if (pos < 19'sd0) begin
            len = len + pos;
            pos = 19'sd0;
        end else if (pos + len > lm) begin
            len = lm - pos;
        end
        if (len < 19'sd0) begin
            pos = 19'sd0;
            len = 19'sd0;
        end
        a.pos = pos[15:0];
        a.len = len[15:0];
        return a;
    endfunction

    // Cursor rectangle overlaps the locked rectangle
    function automatic logic in_lock(input sclc_pkg::state_t s);
        logic signed [18:0] cx;
        logic signed [18:0] cy;
        logic signed [18:0] ll;
        logic signed [18:0] lt;
        cx = $signed({3'b000, s.cur_x}) - $signed({3'b000, s.hot_x});
        cy = $signed({3'b000, s.cur_y}) - $signed({3'b000, s.hot_y});
        ll = $signed({3'b000, s.lock_left});
        lt = $signed({3'b000, s.lock_top});
        return (ll < cx + $signed({3'b000, s.shape_w})) &&
               (lt < cy + $signed({3'b000, s.shape_h})) &&
               (ll + $signed({2'b00, s.lock_w}) > cx) &&
               (lt + $signed({2'b00, s.lock_h}) > cy);
    endfunction

    // Build one result item from the state at the time of the action
    function automatic sclc_pkg::res_item_t emit(input sclc_pkg::action_t act,
                                                input sclc_pkg::state_t s,
                                                input sclc_pkg::cfg_t c);
        sclc_pkg::res_item_t r;
        axis_t               ax;
        axis_t               ay;
        r        = '0;
        r.action = act;
        if (act != sclc_pkg::ACT_NONE) begin
            ax       = clip_axis(s.cur_x, s.hot_x, s.shape_w, c.fb_width);
            ay       = clip_axis(s.cur_y, s.hot_y, s.shape_h, c.fb_height);
            r.area_x = ax.pos;
            r.area_w = ax.len;
            r.area_y = ay.pos;
            r.area_h = ay.len;
        end
        r.now_present = s.present;
        r.now_hidden  = s.hidden;
        return r;
    endfunction

    sclc_pkg::state_t    st;
    sclc_pkg::res_item_t res_v [2];
    logic [1:0]          n;

    always_comb begin
        logic [15:0] mx_x;
        logic [15:0] mx_y;
        logic [15:0] nl;
        logic [15:0] nt;
        logic [16:0] r0;
        logic [16:0] b0;
        logic [17:0] r1;
        logic [17:0] b1;
        logic [17:0] rmax;
        logic [17:0] bmax;
        st       = st_i;
        res_v[0] = '0;
        res_v[1] = '0;
        n        = 2'd0;
        mx_x     = item_i.coord_x;
        mx_y     = item_i.coord_y;
        nl       = '0;
        nt       = '0;
        r0       = '0;
        b0       = '0;
        r1       = '0;
        b1       = '0;
        rmax     = '0;
        bmax     = '0;

        // Clamp server position into the framebuffer
        if (item_i.mode == sclc_pkg::MODE_SERVER) begin
            if (mx_x >= cfg_i.fb_width) begin
                mx_x = (cfg_i.fb_width != 16'd0) ? cfg_i.fb_width - 16'd1 : 16'd0;
            end
            if (mx_y >= cfg_i.fb_height) begin
                mx_y = (cfg_i.fb_height != 16'd0) ? cfg_i.fb_height - 16'd1 : 16'd0;
            end
        end

        unique case (item_i.mode)
            sclc_pkg::MODE_SHAPE: begin
                if (st.present) begin
                    st.present = 1'b0;
                    if (!st.hidden) begin
                        res_v[n[0]] = emit(sclc_pkg::ACT_RESTORE, st, cfg_i);
                        n           = n + 2'd1;
                    end
                end
                if (item_i.size_w != 16'd0 && item_i.size_h != 16'd0 && !cfg_i.ignore_shape) begin
                    st.shape_w = item_i.size_w;
                    st.shape_h = item_i.size_h;
                    // Clamp hotspot into the cursor
                    st.hot_x   = (item_i.coord_x < item_i.size_w) ? item_i.coord_x
                                                                  : item_i.size_w - 16'd1;
                    st.hot_y   = (item_i.coord_y < item_i.size_h) ? item_i.coord_y
                                                                  : item_i.size_h - 16'd1;
                    st.present = 1'b1;
                    st.hidden  = 1'b0;
                    st.locked  = 1'b0;
                    res_v[n[0]] = emit(sclc_pkg::ACT_DRAW, st, cfg_i);
                    n           = n + 2'd1;
                end
            end
            sclc_pkg::MODE_SERVER, sclc_pkg::MODE_MOVE: begin
                if (st.present && !st.hidden) begin
                    st.hidden   = 1'b1;
                    res_v[n[0]] = emit(sclc_pkg::ACT_RESTORE, st, cfg_i);
                    n           = n + 2'd1;
                end
                st.cur_x = mx_x;
                st.cur_y = mx_y;
                if (st.present && !(st.locked && in_lock(st))) begin
                    st.hidden   = 1'b0;
                    res_v[n[0]] = emit(sclc_pkg::ACT_DRAW, st, cfg_i);
                    n           = n + 2'd1;
                end
            end
            sclc_pkg::MODE_LOCK: begin
                if (st.present) begin
                    if (!st.locked) begin
                        st.lock_left = item_i.coord_x;
                        st.lock_top  = item_i.coord_y;
                        st.lock_w    = {1'b0, item_i.size_w};
                        st.lock_h    = {1'b0, item_i.size_h};
                        st.locked    = 1'b1;
                    end else begin
                        // Grow the lock to the bounding union
                        nl   = (item_i.coord_x < st.lock_left) ? item_i.coord_x : st.lock_left;
                        nt   = (item_i.coord_y < st.lock_top) ? item_i.coord_y : st.lock_top;
                        r0   = {1'b0, item_i.coord_x} + {1'b0, item_i.size_w};
                        b0   = {1'b0, item_i.coord_y} + {1'b0, item_i.size_h};
                        r1   = {2'b00, st.lock_left} + {1'b0, st.lock_w};
                        b1   = {2'b00, st.lock_top} + {1'b0, st.lock_h};
                        rmax = ({1'b0, r0} > r1) ? {1'b0, r0} : r1;
                        bmax = ({1'b0, b0} > b1) ? {1'b0, b0} : b1;
                        st.lock_w    = 17'(rmax - {2'b00, nl});
                        st.lock_h    = 17'(bmax - {2'b00, nt});
                        st.lock_left = nl;
                        st.lock_top  = nt;
                    end
                    if (!st.hidden && in_lock(st)) begin
                        st.hidden   = 1'b1;
                        res_v[n[0]] = emit(sclc_pkg::ACT_RESTORE, st, cfg_i);
                        n           = n + 2'd1;
                    end
                end
            end
            sclc_pkg::MODE_UNLOCK: begin
                if (st.present) begin
                    if (st.hidden) begin
                        st.hidden   = 1'b0;
                        res_v[n[0]] = emit(sclc_pkg::ACT_DRAW, st, cfg_i);
                        n           = n + 2'd1;
                    end
                    st.locked = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // Give one none item when nothing happened, then mark the final item
        if (n == 2'd0) begin
            res_v[0] = emit(sclc_pkg::ACT_NONE, st, cfg_i);
            n        = 2'd1;
        end
        if (n == 2'd2) begin
            res_v[1].last = 1'b1;
        end else begin
            res_v[0].last = 1'b1;
        end
    end

    assign ev_o.nxt  = st;
    assign ev_o.res0 = res_v[0];
    assign ev_o.res1 = res_v[1];
    assign ev_o.two  = (n == 2'd2);

endmodule

// ===== sv/soft_cursor_lock_controller_unit.sv =====
// Top level of the software cursor lock controller: input stage, state, result queue, APB.
`timescale 1ns / 1ps
// Latency: the first result of an item goes from the input stage into the result queue, whose head drives m_.
// Throughput: one item per cycle while the result queue has room for two entries; an item with two results
// takes two queue entries, drained one per pop by the single result port of a three-entry result queue.
// Reset (aresetn low, synchronous): cursor absent and hidden, no lock, positions zero,
// framebuffer 640 x 480, shape updates taken; input stage and result queue empty.

module soft_cursor_lock_controller_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sclc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sclc_pkg::res_item_t m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [1:0] REG_FB_WIDTH     = 2'd0;
    localparam logic [1:0] REG_FB_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_IGNORE_SHAPE = 2'd2;

    localparam int QDEPTH = 3;
    localparam int CW     = $clog2(QDEPTH + 1);

    sclc_pkg::cfg_t      cfg_reg;
    sclc_pkg::state_t    st_reg;
    logic                in_valid_reg;
    sclc_pkg::in_item_t  in_item_reg;
    sclc_pkg::res_item_t q_reg  [QDEPTH];
    sclc_pkg::res_item_t q_next [QDEPTH];
    logic [CW-1:0]       q_cnt_reg;
    logic [CW-1:0]       q_cnt_next;
    logic [CW-1:0]       cnt_pop;
    logic                pop;
    logic                advance;
    logic                cfg_wr;
    sclc_pkg::ev_t       ev;

    sclc_event u_event (
        .st_i   (st_reg),
        .item_i (in_item_reg),
        .cfg_i  (cfg_reg),
        .ev_o   (ev)
    );

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fb_width     <= sclc_pkg::FB_WIDTH_RESET;
            cfg_reg.fb_height    <= sclc_pkg::FB_HEIGHT_RESET;
            cfg_reg.ignore_shape <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FB_WIDTH:     cfg_reg.fb_width     <= pwdata[15:0];
                REG_FB_HEIGHT:    cfg_reg.fb_height    <= pwdata[15:0];
                REG_IGNORE_SHAPE: cfg_reg.ignore_shape <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FB_WIDTH:     prdata = {16'd0, cfg_reg.fb_width};
            REG_FB_HEIGHT:    prdata = {16'd0, cfg_reg.fb_height};
            REG_IGNORE_SHAPE: prdata = {31'd0, cfg_reg.ignore_shape};
            default:          prdata = '0;
        endcase
    end

    // Result queue: pop the head, then append this cycle's items behind what remains
    assign m_valid = (q_cnt_reg != '0);
    assign m_item  = q_reg[0];
    assign pop     = m_valid && m_ready;
    assign cnt_pop = q_cnt_reg - CW'(pop);
    assign advance = in_valid_reg && (cnt_pop <= CW'(QDEPTH - 2));
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        q_next[QDEPTH - 1] = q_reg[QDEPTH - 1];
        for (int i = 0; i < QDEPTH; i++) begin
            if (advance && CW'(i) == cnt_pop) begin
                q_next[i] = ev.res0;
            end
            if (advance && ev.two && CW'(i) == cnt_pop + CW'(1)) begin
                q_next[i] = ev.res1;
            end
        end
        q_cnt_next = cnt_pop;
        if (advance) begin
            q_cnt_next = cnt_pop + (ev.two ? CW'(2) : CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // Input stage: hold the item until the event logic takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Cursor and lock state: advance once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.present   <= 1'b0;
            st_reg.hidden    <= 1'b1;
            st_reg.locked    <= 1'b0;
            st_reg.cur_x     <= '0;
            st_reg.cur_y     <= '0;
            st_reg.shape_w   <= '0;
            st_reg.shape_h   <= '0;
            st_reg.hot_x     <= '0;
            st_reg.hot_y     <= '0;
            st_reg.lock_left <= '0;
            st_reg.lock_top  <= '0;
            st_reg.lock_w    <= '0;
            st_reg.lock_h    <= '0;
        end else if (advance) begin
            st_reg <= ev.nxt;
        end
    end

endmodule
